>>> rtl/strict_decimal_int32_parser_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the decimal parser.
// ---------------------------------------------------------------------------
`ifndef STRICT_DECIMAL_INT32_PARSER_TOP_DEFINES_SVH
`define STRICT_DECIMAL_INT32_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SDI32P_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, ignored while reset is asserted.
`define SDI32P_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define SDI32P_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("next-cycle implication failed across reset");

`endif

>>> rtl/sdi32p_pkg.sv
// ---------------------------------------------------------------------------
// sdi32p_pkg
// Types and constants of the strict decimal int32 parser.
// ---------------------------------------------------------------------------
`default_nettype none

package sdi32p_pkg;

  localparam int MAG_W = 34;
  localparam int CNT_W = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [MAG_W-1:0] MAG_SAT   = {MAG_W{1'b1}};
  localparam logic [MAG_W-1:0] POS_LIMIT = 34'd2147483647;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 34'd2147483648;

  localparam logic [CNT_W-1:0] MAX_DIGITS = 4'd10;
  localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;

  typedef struct packed {
    logic             at_start;
    logic             negative;
    logic [MAG_W-1:0] magnitude;
    logic [CNT_W-1:0] digit_count;
    logic             leading_zero;
    logic             bad;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    at_start:     1'b1,
    negative:     1'b0,
    magnitude:    '0,
    digit_count:  '0,
    leading_zero: 1'b0,
    bad:          1'b0
  };

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } parse_result_t;

endpackage

`default_nettype wire

>>> rtl/sdi32p_step.sv
// ---------------------------------------------------------------------------
// sdi32p_step
// Next-state and result logic for one character of the number string.
// ---------------------------------------------------------------------------
`default_nettype none

module sdi32p_step (
  input  sdi32p_pkg::parse_state_t  st_i,
  input  logic [7:0]                ch_i,
  input  logic                      last_i,
  output sdi32p_pkg::parse_state_t  st_o,
  output sdi32p_pkg::parse_result_t res_o
);

  logic                         is_minus;
  logic                         is_digit;
  logic [3:0]                   digit;
  logic [sdi32p_pkg::MAG_W+3:0] mag_ext;
  logic [sdi32p_pkg::MAG_W+3:0] mag_x10;
  logic [sdi32p_pkg::MAG_W-1:0] mag_acc;
  sdi32p_pkg::parse_state_t     upd;
  logic                         err;

  always_comb begin
    is_minus = st_i.at_start && (ch_i == sdi32p_pkg::CH_MINUS);
    is_digit = ch_i inside {[sdi32p_pkg::CH_ZERO:sdi32p_pkg::CH_NINE]};
    digit    = 4'(ch_i - sdi32p_pkg::CH_ZERO);

    // magnitude * 10 + digit as shift-and-add, then saturate.
    mag_ext = {4'b0, st_i.magnitude};
    mag_x10 = (mag_ext << 3) + (mag_ext << 1) + {{(sdi32p_pkg::MAG_W){1'b0}}, digit};
    if (mag_x10 > {4'b0, sdi32p_pkg::MAG_SAT}) begin
      mag_acc = sdi32p_pkg::MAG_SAT;
    end else begin
      mag_acc = mag_x10[sdi32p_pkg::MAG_W-1:0];
    end

    upd          = st_i;
    upd.at_start = 1'b0;
    upd.negative = st_i.negative | is_minus;
    // Anything after a leading zero digit is an error.
    upd.bad      = st_i.bad | st_i.leading_zero | (!is_minus && !is_digit);
    if (is_digit) begin
      upd.magnitude = mag_acc;
      if (st_i.digit_count == '0 && digit == 4'd0) begin
        upd.leading_zero = 1'b1;
      end
      if (st_i.digit_count != sdi32p_pkg::CNT_MAX) begin
        upd.digit_count = st_i.digit_count + 4'd1;
      end
    end

    err = upd.bad
        | (upd.digit_count == '0)
        | (upd.digit_count > sdi32p_pkg::MAX_DIGITS)
        | (upd.negative && upd.magnitude == '0)
        | (upd.negative ? (upd.magnitude > sdi32p_pkg::NEG_LIMIT)
                        : (upd.magnitude > sdi32p_pkg::POS_LIMIT));

    res_o.error = err;
    if (err) begin
      res_o.value = '0;
    end else if (upd.negative) begin
      res_o.value = -$signed(upd.magnitude[31:0]);
    end else begin
      res_o.value = $signed(upd.magnitude[31:0]);
    end

    st_o = last_i ? sdi32p_pkg::STATE_CLEAR : upd;
  end

endmodule

`default_nettype wire

>>> rtl/strict_decimal_int32_parser_top.sv
// ---------------------------------------------------------------------------
// strict_decimal_int32_parser_top
// Streaming parser of decimal number strings into signed 32-bit values.
// ---------------------------------------------------------------------------
// The input channel carries one ASCII character per word (in_ch) with
// in_last marking the final character of a string. A string is an optional
// leading '-' followed by decimal digits. For every word with in_last set,
// one result word appears on the output channel: out_value and out_error,
// where out_value is zero whenever out_error is set.
// A character is captured in an input register and then folded into the
// parse state; the result register is loaded in that same step, so a result
// passes the input register and then the result register on its way out.
// Throughput is one character per cycle, limited by the single parse state
// update in each cycle, except while a last character waits for the result.
// When the receiver stalls, characters that end no string keep flowing into
// the parse state; a last character waits in the input register until the
// result register is free, and in_ready drops only in that case.
// Synchronous reset (rst_n low) empties both registers and returns the parse
// state to the start of a string.
// ---------------------------------------------------------------------------
`default_nettype none

module strict_decimal_int32_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_error
);

  logic                      in_valid_r;
  logic [7:0]                in_ch_r;
  logic                      in_last_r;
  sdi32p_pkg::parse_state_t  state_r;
  sdi32p_pkg::parse_state_t  state_nxt;
  sdi32p_pkg::parse_result_t res;
  logic                      out_valid_r;
  logic signed [31:0]        out_value_r;
  logic                      out_error_r;
  logic                      fire;

  // A held word advances unless it ends a string and the result slot is busy.
  assign fire     = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  sdi32p_step u_step (
    .st_i   (state_r),
    .ch_i   (in_ch_r),
    .last_i (in_last_r),
    .st_o   (state_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r   <= in_ch;
      in_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdi32p_pkg::STATE_CLEAR;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last_r) begin
      out_value_r <= res.value;
      out_error_r <= res.error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule

`default_nettype wire

>>> rtl/sdi32p_checker.sv
// ---------------------------------------------------------------------------
// sdi32p_checker
// Port-level checks of the decimal parser, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "strict_decimal_int32_parser_top_defines.svh"

module sdi32p_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value,
  input logic               out_error
);

  logic        out_stall;
  logic [32:0] out_word;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_value, out_error};

  // A stalled result word keeps its contents.
  `SDI32P_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

  // An error result always carries a zero value.
  `SDI32P_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_error, out_value == 32'sd0)

  // Input backpressure only comes from a stalled result word.
  `SDI32P_ASSERT_IMPL(a_ready_cause, clk, rst_n, !in_ready, out_stall)

  // No result word is shown right after reset.
  `SDI32P_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind strict_decimal_int32_parser_top sdi32p_checker u_sdi32p_checker (.*);

`default_nettype wire

>>> tb/strict_decimal_int32_parser_top_tb.sv
// ---------------------------------------------------------------------------
// strict_decimal_int32_parser_top_tb
// Self-checking testbench of the streaming decimal string to int32 parser.
// ---------------------------------------------------------------------------
// Number strings are sent one character per word, with random sender gaps
// and random receiver stalls. A behavioral parser in the testbench follows
// every accepted word and queues the value and error flag that each string
// must produce. A checker compares every result word with the oldest queued
// expectation. The stimulus starts with hand-picked strings around the int32
// limits and the error rules, then runs random strings, mostly well formed
// with some noise, first with idling and then as one unbroken stream.
// ---------------------------------------------------------------------------

module strict_decimal_int32_parser_top_tb;

  typedef logic [7:0] text_t[$];

  localparam int STALL_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_ch = 8'h00;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic               out_error;

  int in_idle_pct = 15;
  int out_idle_pct = 15;
  int words_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  sdi32p_pkg::parse_state_t  parse_st = sdi32p_pkg::STATE_CLEAR;
  sdi32p_pkg::parse_result_t expected_values[$];
  sdi32p_pkg::parse_result_t oldest_value;

  strict_decimal_int32_parser_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .out_error(out_error)
  );

  always #5 clk = ~clk;

  // Behavioral parser: fold one accepted character into the string state and
  // queue the result when the character closes the string.
  task automatic fold_char(input logic [7:0] ch, input logic last);
    logic                         first;
    logic [3:0]                   digit;
    logic [sdi32p_pkg::MAG_W+3:0] next_mag;
    sdi32p_pkg::parse_result_t    res;
    first = parse_st.at_start;
    parse_st.at_start = 1'b0;
    if (parse_st.leading_zero) parse_st.bad = 1'b1;
    if (first && ch == sdi32p_pkg::CH_MINUS) begin
      parse_st.negative = 1'b1;
    end else if (ch >= sdi32p_pkg::CH_ZERO && ch <= sdi32p_pkg::CH_NINE) begin
      digit = 4'(ch - sdi32p_pkg::CH_ZERO);
      if (parse_st.digit_count == 0 && digit == 0) parse_st.leading_zero = 1'b1;
      if (parse_st.digit_count < sdi32p_pkg::CNT_MAX) parse_st.digit_count++;
      next_mag = {4'b0, parse_st.magnitude} * (sdi32p_pkg::MAG_W+4)'(10)
               + {{(sdi32p_pkg::MAG_W){1'b0}}, digit};
      parse_st.magnitude = (next_mag > {4'b0, sdi32p_pkg::MAG_SAT}) ?
                           sdi32p_pkg::MAG_SAT : next_mag[sdi32p_pkg::MAG_W-1:0];
    end else begin
      parse_st.bad = 1'b1;
    end
    if (last) begin
      res.error = parse_st.bad || parse_st.digit_count == 0 ||
                  parse_st.digit_count > sdi32p_pkg::MAX_DIGITS ||
                  (parse_st.negative && parse_st.magnitude == 0) ||
                  (parse_st.negative ? parse_st.magnitude > sdi32p_pkg::NEG_LIMIT
                                     : parse_st.magnitude > sdi32p_pkg::POS_LIMIT);
      if (res.error) res.value = '0;
      else if (parse_st.negative) res.value = -parse_st.magnitude[31:0];
      else res.value = parse_st.magnitude[31:0];
      expected_values.push_back(res);
      parse_st = sdi32p_pkg::STATE_CLEAR;
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    fold_char(ch, last);
    words_sent++;
  endtask

  task automatic send_text(input text_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic text_t to_text(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // Random string, mostly a well-formed number with random content.
  function automatic text_t make_number_text();
    text_t  t;
    string  sign;
    int     v;
    longint m;
    int     len;
    if ($urandom_range(1)) sign = "-";
    else sign = "";
    case ($urandom_range(9))
      0, 1, 2: begin
        v = $urandom();
        t = to_text($sformatf("%0d", v));
      end
      3: t = to_text($sformatf("%s%0d", sign, $urandom_range(999)));
      4: begin
        // Magnitudes straddling both int32 limits.
        m = 64'd2147483640 + $urandom_range(16);
        t = to_text($sformatf("%s%0d", sign, m));
      end
      5: begin
        t = to_text(sign);
        len = $urandom_range(1, 20);
        repeat (len) t.push_back(8'(sdi32p_pkg::CH_ZERO + $urandom_range(9)));
      end
      6: begin
        v = $urandom();
        t = to_text($sformatf("%0d", v));
        t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
      end
      7: begin
        len = $urandom_range(1, 4);
        repeat (len) t.push_back(8'($urandom_range(255)));
      end
      8: begin
        t = to_text({sign, "0"});
        len = $urandom_range(2);
        repeat (len) t.push_back(8'(sdi32p_pkg::CH_ZERO + $urandom_range(9)));
      end
      default: begin
        t = to_text("-");
        if ($urandom_range(1)) t.push_back(8'($urandom_range(255)));
      end
    endcase
    return t;
  endfunction

  task automatic test_directed_cases();
    string cases[$];
    cases = '{"0", "7", "2147483647", "-2147483648", "2147483648", "-2147483649",
              "-", "-0", "00", "007", "-0000000001", "12a", "a", "--5", "1-",
              "/", ":", "9999999999", "12345678901", "99999999999999999999",
              "-1", "1000000000"};
    foreach (cases[i]) send_text(to_text(cases[i]));
    // Characters at the ends of the byte range.
    send_char(8'h00, 1'b1);
    send_char(sdi32p_pkg::CH_ZERO + 8'd5, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_random_strings(input int word_target);
    while (words_sent < word_target) send_text(make_number_text());
  endtask

  task automatic test_streaming_no_gaps(input int word_target);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (words_sent < word_target) send_text(make_number_text());
    in_idle_pct  = 15;
    out_idle_pct = 15;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: result word with none expected, value %0d error %0b",
                 $time, out_value, out_error);
        mismatch_count++;
      end else begin
        oldest_value = expected_values.pop_front();
        if (out_value !== oldest_value.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, oldest_value.value, out_value);
          mismatch_count++;
        end
        if (out_error !== oldest_value.error) begin
          $display("%0t: error flag mismatch, expected %0b, actual %0b",
                   $time, oldest_value.error, out_error);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_strings(580);
    test_streaming_no_gaps(720);
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> strict_decimal_int32_parser_top.f
+incdir+rtl
rtl/sdi32p_pkg.sv
rtl/sdi32p_step.sv
rtl/strict_decimal_int32_parser_top.sv
rtl/sdi32p_checker.sv
tb/strict_decimal_int32_parser_top_tb.sv
